FILE: rtl/core/xml_css_char_escaper_defines.svh
// Assertion macros shared by the escaper RTL.
`ifndef XML_CSS_CHAR_ESCAPER_DEFINES_SVH
`define XML_CSS_CHAR_ESCAPER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define XCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define XCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/xce_pkg.sv
// Types, constants and character tables for the XML/CSS character escaper.
package xce_pkg;

  localparam int CHAR_W  = 21;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int THR_W   = 24;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [1:0]        mode_t;
  typedef logic [2:0]        digit_idx_t;
  typedef logic [THR_W-1:0]  thr_t;

  localparam mode_t MODE_TEXT = 2'd0;
  localparam mode_t MODE_ATTR = 2'd1;
  localparam mode_t MODE_CSS  = 2'd2;

  localparam logic REG_ESCAPE_MODE = 1'b0;

  localparam digit_idx_t DEC_LAST_IDX = 3'd6;
  localparam digit_idx_t HEX_TOP_IDX  = 3'd5;

  localparam char_t CH_QUOT   = 21'h22;
  localparam char_t CH_HASH   = 21'h23;
  localparam char_t CH_AMP    = 21'h26;
  localparam char_t CH_ZERO   = 21'h30;
  localparam char_t CH_SEMI   = 21'h3B;
  localparam char_t CH_LT     = 21'h3C;
  localparam char_t CH_GT     = 21'h3E;
  localparam char_t CH_UPPER_A = 21'h41;
  localparam char_t CH_BSLASH = 21'h5C;
  localparam char_t CH_LOW_A  = 21'h61;
  localparam char_t CH_LOW_G  = 21'h67;
  localparam char_t CH_LOW_L  = 21'h6C;
  localparam char_t CH_LOW_M  = 21'h6D;
  localparam char_t CH_LOW_O  = 21'h6F;
  localparam char_t CH_LOW_P  = 21'h70;
  localparam char_t CH_LOW_Q  = 21'h71;
  localparam char_t CH_LOW_T  = 21'h74;
  localparam char_t CH_LOW_U  = 21'h75;

  typedef enum logic [1:0] {JOB_PASS, JOB_ENT, JOB_DEC, JOB_HEX} job_kind_t;
  typedef enum logic [1:0] {ENT_LT, ENT_GT, ENT_AMP, ENT_QUOT} ent_t;

  typedef struct packed {
    job_kind_t  kind;
    ent_t       ent;
    digit_idx_t start;
    char_t      cp;
  } job_t;

  // Decimal place weight, most significant place first.
  function automatic thr_t dec_weight(digit_idx_t idx);
    thr_t w;
    case (idx)
      3'd0:    w = 24'd1000000;
      3'd1:    w = 24'd100000;
      3'd2:    w = 24'd10000;
      3'd3:    w = 24'd1000;
      3'd4:    w = 24'd100;
      3'd5:    w = 24'd10;
      default: w = 24'd1;
    endcase
    return w;
  endfunction

  function automatic char_t hex_char(logic [3:0] nib);
    char_t c;
    if (nib < 4'd10) c = CH_ZERO + char_t'(nib);
    else             c = CH_UPPER_A + char_t'(nib - 4'd10);
    return c;
  endfunction

  // Position of the closing semicolon of each entity.
  function automatic digit_idx_t ent_last(ent_t ent);
    digit_idx_t p;
    case (ent)
      ENT_AMP:  p = 3'd4;
      ENT_QUOT: p = 3'd5;
      default:  p = 3'd3;
    endcase
    return p;
  endfunction

  function automatic char_t ent_char(ent_t ent, digit_idx_t pos);
    char_t c;
    c = CH_SEMI;
    if (pos == 3'd0) begin
      c = CH_AMP;
    end else begin
      case (ent)
        ENT_LT: begin
          if (pos == 3'd1) c = CH_LOW_L;
          else if (pos == 3'd2) c = CH_LOW_T;
        end
        ENT_GT: begin
          if (pos == 3'd1) c = CH_LOW_G;
          else if (pos == 3'd2) c = CH_LOW_T;
        end
        ENT_AMP: begin
          if (pos == 3'd1) c = CH_LOW_A;
          else if (pos == 3'd2) c = CH_LOW_M;
          else if (pos == 3'd3) c = CH_LOW_P;
        end
        default: begin
          if (pos == 3'd1) c = CH_LOW_Q;
          else if (pos == 3'd2) c = CH_LOW_U;
          else if (pos == 3'd3) c = CH_LOW_O;
          else if (pos == 3'd4) c = CH_LOW_T;
        end
      endcase
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/xce_if.sv
// Valid/ready channel interfaces for escaper input items and result characters.
interface xce_in_if import xce_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t code_point;
  logic  encodable;

  modport source (output valid, code_point, encodable, input ready);
  modport sink   (input valid, code_point, encodable, output ready);
endinterface

interface xce_out_if import xce_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t out_char;
  logic  last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

FILE: rtl/core/xml_css_char_escaper.sv
// Throughput: one result per cycle while out_ch is ready; an item holds the output
// sequencer until its last result is sent, so pass-through characters flow at one
// item per cycle when the output does not stall. Escape forms are 2 to 10
// characters long (entities 4-6, decimal 4 to 10, hex 2 to 7).
// Reset: synchronous; clears the escape mode to text and drops all pending items.
`include "xml_css_char_escaper_defines.svh"

module xml_css_char_escaper import xce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  xce_in_if.sink             in_ch,
  xce_out_if.source          out_ch
);

  mode_t escape_mode;
  job_t  job;
  logic  job_valid;
  logic  job_ready;

  xce_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .escape_mode (escape_mode)
  );

  xce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .escape_mode (escape_mode),
    .job         (job),
    .job_valid   (job_valid),
    .job_ready   (job_ready)
  );

  xce_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .out_ch    (out_ch)
  );

  `XCE_ASSERT_IMPLY(a_load_needs_free_out, job_valid && job_ready, !out_ch.valid || out_ch.ready, "job loaded while output register blocked")
  `XCE_ASSERT_NEXT(a_burst_no_bubble, out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid, "gap inside an escape sequence")
  `XCE_ASSERT_IMPLY(a_no_load_mid_seq, out_ch.valid && !out_ch.last, !job_ready, "new job taken before sequence ended")

endmodule

FILE: rtl/core/xce_regs.sv
// APB register file holding the escape mode.
module xce_regs import xce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output mode_t              escape_mode
);

  logic reg_idx;
  logic wr_en;

  assign reg_idx = paddr[PADDR_W-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= MODE_TEXT;
    end else if (wr_en && (reg_idx == REG_ESCAPE_MODE)) begin
      escape_mode <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_ESCAPE_MODE) prdata = {{(PDATA_W-2){1'b0}}, escape_mode};
  end

endmodule

FILE: rtl/core/xce_front.sv
// Input register and per-character classification into an escape job.
module xce_front import xce_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  xce_in_if.sink         in_ch,
  input  mode_t          escape_mode,
  output job_t           job,
  output logic           job_valid,
  input  logic           job_ready
);

  logic  item_valid;
  char_t item_cp;
  logic  item_enc;
  logic  css;
  logic  attr;
  digit_idx_t dec_start;
  digit_idx_t hex_start;

  assign in_ch.ready = !item_valid || job_ready;
  assign job_valid   = item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_cp  <= in_ch.code_point;
      item_enc <= in_ch.encodable;
    end
  end

  // Leading place of the decimal and hex forms, so no leading zero digit is walked.
  always_comb begin
    dec_start = DEC_LAST_IDX;
    for (int k = 5; k >= 0; k--) begin
      if ({3'b000, item_cp} >= dec_weight(digit_idx_t'(k))) dec_start = digit_idx_t'(k);
    end
    hex_start = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if ({3'b000, item_cp} >= (thr_t'(1) << (4 * k))) hex_start = digit_idx_t'(k);
    end
  end

  assign css  = (escape_mode == MODE_CSS);
  assign attr = (escape_mode == MODE_ATTR);

  always_comb begin
    job.cp    = item_cp;
    job.ent   = ENT_LT;
    job.start = dec_start;
    job.kind  = JOB_PASS;
    if (css) begin
      job.start = hex_start;
      if (!item_enc) job.kind = JOB_HEX;
    end else if (item_cp == CH_LT) begin
      job.kind = JOB_ENT;
    end else if (item_cp == CH_GT) begin
      job.kind = JOB_ENT;
      job.ent  = ENT_GT;
    end else if (item_cp == CH_AMP) begin
      job.kind = JOB_ENT;
      job.ent  = ENT_AMP;
    end else if (attr && (item_cp == CH_QUOT)) begin
      job.kind = JOB_ENT;
      job.ent  = ENT_QUOT;
    end else if (!item_enc) begin
      job.kind = JOB_DEC;
    end
  end

endmodule

FILE: rtl/core/xce_serial.sv
// Output sequencer: emits one character of the escaped form per transfer.
module xce_serial import xce_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  job_t   job,
  input  logic   job_valid,
  output logic   job_ready,
  xce_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_ENT, S_HASH, S_DEC, S_SEMI, S_HEX} state_t;

  state_t     state, state_next;
  ent_t       ent, ent_next;
  digit_idx_t idx, idx_next;
  char_t      rem, rem_next;
  logic       out_valid, out_valid_next;
  char_t      out_char, out_char_next;
  logic       out_last, out_last_next;

  logic       out_free;
  thr_t       thr [10];
  logic [3:0] digit;
  char_t      rem_dig;
  logic [23:0] hex_src;
  logic [3:0] nib;

  assign out_ch.valid    = out_valid;
  assign out_ch.out_char = out_char;
  assign out_ch.last     = out_last;

  assign out_free  = !out_valid || out_ch.ready;
  assign job_ready = (state == S_IDLE) && out_free;

  // One decimal digit: compare against all nine multiples of the place weight.
  always_comb begin
    digit = 4'd0;
    for (int k = 0; k < 10; k++) begin
      thr[k] = thr_t'(k) * dec_weight(idx);
    end
    for (int k = 1; k < 10; k++) begin
      if ({3'b000, rem} >= thr[k]) digit = digit + 4'd1;
    end
    rem_dig = char_t'({3'b000, rem} - thr[digit]);
  end

  assign hex_src = {3'b000, rem};
  assign nib     = hex_src[{idx, 2'b00} +: 4];

  always_comb begin
    state_next     = state;
    ent_next       = ent;
    idx_next       = idx;
    rem_next       = rem;
    out_valid_next = out_valid && !out_ch.ready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    if (out_free) begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            rem_next       = job.cp;
            idx_next       = job.start;
            ent_next       = job.ent;
            unique case (job.kind)
              JOB_PASS: begin
                out_char_next = job.cp;
                out_last_next = 1'b1;
              end
              JOB_ENT: begin
                out_char_next = CH_AMP;
                idx_next      = 3'd1;
                state_next    = S_ENT;
              end
              JOB_DEC: begin
                out_char_next = CH_AMP;
                state_next    = S_HASH;
              end
              JOB_HEX: begin
                out_char_next = CH_BSLASH;
                state_next    = S_HEX;
              end
              default: begin
                out_char_next = job.cp;
                out_last_next = 1'b1;
              end
            endcase
          end
        end
        S_ENT: begin
          out_valid_next = 1'b1;
          out_char_next  = ent_char(ent, idx);
          out_last_next  = (idx == ent_last(ent));
          idx_next       = idx + 3'd1;
          if (idx == ent_last(ent)) state_next = S_IDLE;
        end
        S_HASH: begin
          out_valid_next = 1'b1;
          out_char_next  = CH_HASH;
          out_last_next  = 1'b0;
          state_next     = S_DEC;
        end
        S_DEC: begin
          out_valid_next = 1'b1;
          out_char_next  = CH_ZERO + char_t'(digit);
          out_last_next  = 1'b0;
          rem_next       = rem_dig;
          idx_next       = idx + 3'd1;
          if (idx == DEC_LAST_IDX) state_next = S_SEMI;
        end
        S_SEMI: begin
          out_valid_next = 1'b1;
          out_char_next  = CH_SEMI;
          out_last_next  = 1'b1;
          state_next     = S_IDLE;
        end
        S_HEX: begin
          out_valid_next = 1'b1;
          out_char_next  = hex_char(nib);
          out_last_next  = (idx == 3'd0);
          idx_next       = idx - 3'd1;
          if (idx == 3'd0) state_next = S_IDLE;
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    ent      <= ent_next;
    idx      <= idx_next;
    rem      <= rem_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

endmodule

FILE: verif/xml_css_char_escaper_tb.sv
// Self-checking testbench for the XML/CSS character escaper: directed and random streams.
module xml_css_char_escaper_tb;
  import xce_pkg::*;

  localparam mode_t MODE_TEXT_ALIAS = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_ESCAPE_MODE = PADDR_W'(4 * REG_ESCAPE_MODE);
  localparam string HEX_DIGITS = "0123456789ABCDEF";

  typedef struct {
    char_t ch;
    logic  last;
  } esc_char_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  xce_in_if  in_ch ();
  xce_out_if out_ch ();

  xml_css_char_escaper dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  mode_t     esc_mode;
  esc_char_t expected_chars[$];
  int        src_idle_pct;
  int        recv_stall_pct;
  int        chars_sent;
  int        chars_checked;
  int        mismatches;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected escaped form of one input character under the current mode.
  function automatic void predict_escape(input char_t cp, input logic enc);
    char_t        seq[$];
    string        ent;
    logic [23:0]  rem;
    logic [3:0]   nib;
    int unsigned  weights[7];
    int unsigned  digit;
    bit           started;
    bit           attr;
    int           i;
    weights = '{1000000, 100000, 10000, 1000, 100, 10, 1};
    ent = "";
    started = 0;
    if (esc_mode == MODE_CSS) begin
      if (enc) begin
        seq.push_back(cp);
      end else begin
        seq.push_back(CH_BSLASH);
        rem = {3'b000, cp};
        for (i = 5; i >= 0; i--) begin
          nib = rem[i*4 +: 4];
          if (nib != 4'd0 || started || i == 0) begin
            seq.push_back(char_t'(HEX_DIGITS[nib]));
            started = 1;
          end
        end
      end
    end else begin
      attr = (esc_mode == MODE_ATTR);
      if (cp == CH_LT) ent = "&lt;";
      else if (cp == CH_GT) ent = "&gt;";
      else if (cp == CH_AMP) ent = "&amp;";
      else if (attr && cp == CH_QUOT) ent = "&quot;";
      if (ent.len() != 0) begin
        for (i = 0; i < ent.len(); i++) seq.push_back(char_t'(ent[i]));
      end else if (enc) begin
        seq.push_back(cp);
      end else begin
        seq.push_back(CH_AMP);
        seq.push_back(CH_HASH);
        rem = {3'b000, cp};
        for (i = 0; i < 7; i++) begin
          digit = rem / weights[i];
          rem = rem % weights[i];
          if (digit != 0 || started || i == 6) begin
            seq.push_back(CH_ZERO + char_t'(digit));
            started = 1;
          end
        end
        seq.push_back(CH_SEMI);
      end
    end
    for (i = 0; i < seq.size(); i++) begin
      expected_chars.push_back('{ch: seq[i], last: (i == seq.size() - 1)});
    end
  endfunction

  // Receiver: stall at the configured rate, changing ready on the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    esc_char_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_char=%h last=%b", out_ch.out_char, out_ch.last);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.out_char !== want.ch) begin
          $error("out_char mismatch: expected %h, got %h", want.ch, out_ch.out_char);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last mismatch: expected %b, got %b", want.last, out_ch.last);
          mismatches++;
        end
        chars_checked++;
      end
    end
  end

  task automatic send_char(input char_t cp, input logic enc);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.code_point <= cp;
    in_ch.encodable  <= enc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_escape(cp, enc);
    chars_sent++;
  endtask

  // Drop valid, drain every expected result, then let the sequencer settle.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_escape_mode(input logic [PDATA_W-1:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ESCAPE_MODE;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    esc_mode = mode_t'(value[1:0]);
  endtask

  function automatic char_t rand_code_point();
    int unsigned sel;
    int unsigned k;
    int unsigned base;
    char_t c;
    sel = $urandom_range(99);
    if (sel < 25) begin
      case ($urandom_range(3))
        0:       c = CH_LT;
        1:       c = CH_GT;
        2:       c = CH_AMP;
        default: c = CH_QUOT;
      endcase
    end else if (sel < 50) begin
      c = char_t'($urandom_range(126, 32));
    end else if (sel < 75) begin
      c = char_t'($urandom);
    end else if (sel < 85) begin
      c = char_t'($urandom_range(15));
    end else begin
      // land on or just under a digit-count boundary
      if ($urandom_range(1)) begin
        k = $urandom_range(6);
        base = 1;
        repeat (k) base = base * 10;
      end else begin
        k = $urandom_range(5);
        base = 1 << (4 * k);
      end
      c = char_t'(base - $urandom_range(1));
    end
    return c;
  endfunction

  task automatic test_text_entities();
    write_escape_mode(PDATA_W'(MODE_TEXT));
    send_char(CH_LT, 1'b1);
    send_char(CH_GT, 1'b0);
    send_char(CH_AMP, 1'b0);
    send_char(CH_QUOT, 1'b1);
    send_char(CH_QUOT, 1'b0);
    send_char(char_t'(0), 1'b1);
  endtask

  task automatic test_decimal_extremes();
    send_char(char_t'(0), 1'b0);
    send_char(char_t'(9), 1'b0);
    send_char(char_t'(1000000), 1'b0);
    send_char(char_t'(21'h10FFFF), 1'b0);
    send_char(char_t'(21'h1FFFFF), 1'b0);
    send_char(char_t'(21'h1FFFFF), 1'b1);
  endtask

  task automatic test_attr_entities();
    write_escape_mode(PDATA_W'(MODE_ATTR));
    send_char(CH_QUOT, 1'b0);
    send_char(CH_QUOT, 1'b1);
    send_char(CH_LT, 1'b0);
    send_char(char_t'(21'h1FFFFF), 1'b0);
  endtask

  task automatic test_css_hex();
    write_escape_mode(PDATA_W'(MODE_CSS));
    send_char(CH_LT, 1'b1);
    send_char(CH_AMP, 1'b0);
    send_char(char_t'(0), 1'b0);
    send_char(char_t'(21'hF), 1'b0);
    send_char(char_t'(21'h100000), 1'b0);
    send_char(char_t'(21'h1FFFFF), 1'b0);
  endtask

  // Mode three aliases text mode; upper write bits must be ignored.
  task automatic test_mode_three();
    write_escape_mode({{(PDATA_W-2){1'b1}}, MODE_TEXT_ALIAS});
    send_char(CH_QUOT, 1'b0);
    send_char(CH_AMP, 1'b1);
  endtask

  task automatic test_random_stream(input int src_pct, input int rcv_pct, input int count);
    logic [PDATA_W-1:0] value;
    int i;
    src_idle_pct   = src_pct;
    recv_stall_pct = rcv_pct;
    for (i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        value = PDATA_W'($urandom_range(3));
        if ($urandom_range(3) == 0) value = value | ($urandom & 32'hFFFF_FFFC);
        write_escape_mode(value);
      end
      send_char(rand_code_point(), $urandom_range(99) < 70);
    end
  endtask

  initial begin
    int guard;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.code_point = '0;
    in_ch.encodable = 1'b0;
    out_ch.ready = 1'b0;
    esc_mode = MODE_TEXT;
    src_idle_pct = 0;
    recv_stall_pct = 0;
    chars_sent = 0;
    chars_checked = 0;
    mismatches = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_text_entities();
    test_decimal_extremes();
    test_attr_entities();
    test_css_hex();
    test_mode_three();
    test_random_stream(0, 0, 95);
    test_random_stream(48, 0, 95);
    test_random_stream(0, 48, 95);
    test_random_stream(9, 9, 95);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    guard = 0;
    while (expected_chars.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_chars.size() != 0) begin
      $error("%0d expected results never arrived", expected_chars.size());
      mismatches++;
    end
    repeat (12) @(posedge clk);

    $display("Sent %0d characters, checked %0d escaped results across text, attribute,",
             chars_sent, chars_checked);
    $display("CSS and aliased text modes with input gaps and output stalls.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/xce_pkg.sv
rtl/core/xce_if.sv
rtl/core/xce_regs.sv
rtl/core/xce_front.sv
rtl/core/xce_serial.sv
rtl/core/xml_css_char_escaper.sv
verif/xml_css_char_escaper_tb.sv
